@@ rtl/core/clep_pkg.sv @@
// Types, codes and character constants shared by the command line parser.
`default_nettype none

package clep_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_word_t;

  typedef struct packed {
    logic       is_verdict;
    logic       in_data_part;
    logic [7:0] out_byte;
    logic [2:0] command_code;
    logic       range_flag;
    logic [2:0] status;
  } out_word_t;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_KEY    = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_EOL    = 5'b01000,
    PH_IGNORE = 5'b10000
  } phase_e;

  typedef enum logic [3:0] {
    ESC_NONE   = 4'b0001,
    ESC_SLASH  = 4'b0010,
    ESC_HEX_HI = 4'b0100,
    ESC_HEX_LO = 4'b1000
  } esc_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_GET    = 3'd1,
    CMD_COUNT  = 3'd2,
    CMD_PUT    = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_COMMIT = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_ESCAPE   = 3'd2,
    ST_COLON    = 3'd3,
    ST_TRAILING = 3'd4
  } status_e;

  localparam logic [7:0] CH_GET     = 8'h3F;  // ?
  localparam logic [7:0] CH_COUNT   = 8'h23;  // #
  localparam logic [7:0] CH_PUT     = 8'h2B;  // +
  localparam logic [7:0] CH_REMOVE  = 8'h2D;  // -
  localparam logic [7:0] CH_COMMIT  = 8'h21;  // !
  localparam logic [7:0] CH_COMMENT = 8'h3E;  // >
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LOW_R   = 8'h72;
  localparam logic [7:0] CH_LOW_N   = 8'h6E;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  // Bit 4 set marks a character that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/command_line_escape_parser_unit.sv @@
// Top level of the command line parser with escape decoding.
//
//   channel | dir | handshake               | word
//   in      | in  | in_valid_i / in_stall_o | in_word_t  (char_code, line_end)
//   out     | out | out_valid_o/out_stall_i | out_word_t (byte or verdict)
//
// One word per cycle while the output is not stalled; an accepted word passes
// through the input register, then is decoded into the result register.
// Parser state updates as each word leaves the input register.
// Reset clears parser state and valid flags to line start; no clearing pass.
// An output stall holds a full result register and, once the input register
// is also full, raises in_stall_o in the same cycle.
`default_nettype none

module command_line_escape_parser_unit
  import clep_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  logic      word_valid;
  in_word_t  word;
  logic      res_valid;
  out_word_t res;
  logic      out_free;
  logic      advance;

  assign advance = word_valid && out_free;

  clep_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .take_i      (advance),
    .word_valid_o(word_valid),
    .word_o      (word)
  );

  clep_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .word_i     (word),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  clep_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && res_valid),
    .res_i      (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/clep_in_stage.sv @@
// Input register stage: holds one incoming word until the parser takes it.
`default_nettype none

module clep_in_stage
  import clep_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_word_i,
  input  wire logic     take_i,
  output logic          word_valid_o,
  output in_word_t      word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;

  assign in_stall_o = valid_q && !take_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      word_q <= in_word_i;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

`default_nettype wire

@@ rtl/core/clep_step.sv @@
// Parser state and per-character decode: command, escapes, separators, verdict.
`default_nettype none

module clep_step
  import clep_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     advance_i,
  input  wire in_word_t word_i,
  output logic          res_valid_o,
  output out_word_t     res_o
);

  phase_e     phase_q, phase_d;
  esc_e       esc_q, esc_d;
  logic [3:0] nib_q, nib_d;
  cmd_e       cmd_q, cmd_d;
  logic       range_q, range_d;
  status_e    status_q, status_d;

  logic       fail_en;
  status_e    fail_code;
  logic       emit_en;
  logic [7:0] emit_byte;
  logic [4:0] hex;
  logic [7:0] c;
  status_e    final_status;

  assign c   = word_i.char_code;
  assign hex = hex_value(c);

  always_comb begin
    phase_d      = phase_q;
    esc_d        = esc_q;
    nib_d        = nib_q;
    cmd_d        = cmd_q;
    range_d      = range_q;
    status_d     = status_q;
    fail_en      = 1'b0;
    fail_code    = ST_OK;
    emit_en      = 1'b0;
    emit_byte    = c;
    final_status = status_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (word_i.line_end) begin
      if (esc_q != ESC_NONE) begin
        if (status_q == ST_OK) final_status = ST_ESCAPE;
      end else if (phase_q == PH_KEY && cmd_q == CMD_PUT) begin
        if (status_q == ST_OK) final_status = ST_COLON;
      end
      res_valid_o        = 1'b1;
      res_o.is_verdict   = 1'b1;
      res_o.command_code = cmd_q;
      res_o.range_flag   = range_q;
      res_o.status       = final_status;
      phase_d  = PH_START;
      esc_d    = ESC_NONE;
      nib_d    = 4'd0;
      cmd_d    = CMD_NONE;
      range_d  = 1'b0;
      status_d = ST_OK;
    end else begin
      case (phase_q)
        PH_START: begin
          case (c)
            CH_GET: begin
              cmd_d = CMD_GET;
              phase_d = PH_KEY;
            end
            CH_COUNT: begin
              cmd_d = CMD_COUNT;
              phase_d = PH_KEY;
            end
            CH_PUT: begin
              cmd_d = CMD_PUT;
              phase_d = PH_KEY;
            end
            CH_REMOVE: begin
              cmd_d = CMD_REMOVE;
              phase_d = PH_KEY;
            end
            CH_COMMIT: begin
              cmd_d = CMD_COMMIT;
              phase_d = PH_EOL;
            end
            CH_COMMENT: phase_d = PH_IGNORE;
            default: begin
              fail_en = 1'b1;
              fail_code = ST_UNKNOWN;
            end
          endcase
        end
        PH_KEY, PH_DATA: begin
          case (esc_q)
            ESC_SLASH: begin
              esc_d = ESC_NONE;
              case (c)
                CH_LOW_T: begin
                  emit_en = 1'b1;
                  emit_byte = CH_TAB;
                end
                CH_LOW_R: begin
                  emit_en = 1'b1;
                  emit_byte = CH_CR;
                end
                CH_LOW_N: begin
                  emit_en = 1'b1;
                  emit_byte = CH_LF;
                end
                CH_BSLASH, CH_STAR, CH_COLON: emit_en = 1'b1;
                CH_LOW_X: esc_d = ESC_HEX_HI;
                default: begin
                  fail_en = 1'b1;
                  fail_code = ST_ESCAPE;
                end
              endcase
            end
            ESC_HEX_HI: begin
              if (hex[4]) begin
                fail_en = 1'b1;
                fail_code = ST_ESCAPE;
              end else begin
                nib_d = hex[3:0];
                esc_d = ESC_HEX_LO;
              end
            end
            ESC_HEX_LO: begin
              if (hex[4]) begin
                fail_en = 1'b1;
                fail_code = ST_ESCAPE;
              end else begin
                esc_d = ESC_NONE;
                emit_en = 1'b1;
                emit_byte = {nib_q, hex[3:0]};
              end
            end
            default: begin
              if (c == CH_BSLASH) begin
                esc_d = ESC_SLASH;
              end else if (c == CH_COLON) begin
                if (phase_q == PH_KEY && cmd_q == CMD_PUT) begin
                  phase_d = PH_DATA;
                end else begin
                  fail_en = 1'b1;
                  fail_code = ST_TRAILING;
                end
              end else if (c == CH_STAR) begin
                if (phase_q == PH_DATA) begin
                  fail_en = 1'b1;
                  fail_code = ST_TRAILING;
                end else if (cmd_q == CMD_PUT) begin
                  fail_en = 1'b1;
                  fail_code = ST_COLON;
                end else begin
                  range_d = 1'b1;
                  phase_d = PH_EOL;
                end
              end else begin
                emit_en = 1'b1;
              end
            end
          endcase
        end
        PH_EOL: begin
          fail_en = 1'b1;
          fail_code = ST_TRAILING;
        end
        default: ;
      endcase

      if (fail_en) begin
        phase_d = PH_IGNORE;
        esc_d   = ESC_NONE;
        if (status_q == ST_OK) status_d = fail_code;
      end

      res_valid_o        = emit_en;
      res_o.in_data_part = (phase_q == PH_DATA);
      res_o.out_byte     = emit_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      esc_q    <= ESC_NONE;
      nib_q    <= 4'd0;
      cmd_q    <= CMD_NONE;
      range_q  <= 1'b0;
      status_q <= ST_OK;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      nib_q    <= nib_d;
      cmd_q    <= cmd_d;
      range_q  <= range_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/clep_out_stage.sv @@
// Result register stage: holds one result word until downstream takes it.
`default_nettype none

module clep_out_stage
  import clep_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_word_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  logic      valid_q, valid_d;
  out_word_t word_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = free_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      word_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

@@ rtl/core/clep_checker.sv @@
// Port-level checks for the command line parser, bound to the top level.
`default_nettype none

module clep_checker
  import clep_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled result word changed");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.is_verdict |->
      out_word_i.command_code == CMD_NONE && !out_word_i.range_flag &&
      out_word_i.status == ST_OK)
    else $error("byte word carries verdict fields");

  a_verdict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.is_verdict |->
      !out_word_i.in_data_part && out_word_i.out_byte == 8'd0 &&
      (out_word_i.status != ST_UNKNOWN || out_word_i.command_code == CMD_NONE))
    else $error("verdict word malformed");

  a_colon_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.is_verdict && out_word_i.status == ST_COLON |->
      out_word_i.command_code == CMD_PUT)
    else $error("missing colon reported for a command other than put");

endmodule

bind command_line_escape_parser_unit clep_checker u_clep_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_i (out_word_o)
);

`default_nettype wire

@@ bench/clep_parse_checker.sv @@
`timescale 1ns / 100ps
// Checker for the command line parser: predicts each result word and compares it.
module clep_parse_checker
  import clep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        pending_o
);

  phase_e     phase;
  esc_e       esc;
  logic [3:0] held_hi;
  cmd_e       cmd;
  logic       range_seen;
  status_e    status;
  out_word_t  expected_words[$];

  function automatic void clear_line();
    phase      = PH_START;
    esc        = ESC_NONE;
    held_hi    = 4'h0;
    cmd        = CMD_NONE;
    range_seen = 1'b0;
    status     = ST_OK;
  endfunction

  function automatic void abort_line(input status_e code);
    if (status == ST_OK) begin
      status = code;
    end
    phase = PH_IGNORE;
    esc   = ESC_NONE;
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] low;
    low = c | 8'h20;
    v   = 4'h0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (low >= "a" && low <= "f") begin
      v = 4'(low - "a" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit emit(input logic [7:0] b, output out_word_t r);
    r              = '0;
    r.in_data_part = (phase == PH_DATA);
    r.out_byte     = b;
    return 1'b1;
  endfunction

  function automatic bit value_step(input logic [7:0] c, output out_word_t r);
    logic [3:0] nib;
    r = '0;
    case (esc)
      ESC_SLASH: begin
        esc = ESC_NONE;
        case (c)
          CH_LOW_T: return emit(CH_TAB, r);
          CH_LOW_R: return emit(CH_CR, r);
          CH_LOW_N: return emit(CH_LF, r);
          CH_BSLASH, CH_STAR, CH_COLON: return emit(c, r);
          CH_LOW_X: esc = ESC_HEX_HI;
          default: abort_line(ST_ESCAPE);
        endcase
        return 1'b0;
      end
      ESC_HEX_HI, ESC_HEX_LO: begin
        if (!hex_nibble(c, nib)) begin
          abort_line(ST_ESCAPE);
          return 1'b0;
        end
        if (esc == ESC_HEX_HI) begin
          held_hi = nib;
          esc     = ESC_HEX_LO;
          return 1'b0;
        end
        esc = ESC_NONE;
        return emit({held_hi, nib}, r);
      end
      default: ;
    endcase
    case (c)
      CH_BSLASH: esc = ESC_SLASH;
      CH_COLON: begin
        if (phase == PH_KEY && cmd == CMD_PUT) begin
          phase = PH_DATA;
        end else begin
          abort_line(ST_TRAILING);
        end
      end
      CH_STAR: begin
        if (phase == PH_DATA) begin
          abort_line(ST_TRAILING);
        end else if (cmd == CMD_PUT) begin
          abort_line(ST_COLON);
        end else begin
          range_seen = 1'b1;
          phase      = PH_EOL;
        end
      end
      default: return emit(c, r);
    endcase
    return 1'b0;
  endfunction

  function automatic bit predict_word(input in_word_t w, output out_word_t r);
    r = '0;
    if (w.line_end) begin
      if (esc != ESC_NONE) begin
        abort_line(ST_ESCAPE);
      end else if (phase == PH_KEY && cmd == CMD_PUT) begin
        abort_line(ST_COLON);
      end
      r.is_verdict   = 1'b1;
      r.command_code = cmd;
      r.range_flag   = range_seen;
      r.status       = status;
      clear_line();
      return 1'b1;
    end
    case (phase)
      PH_START: begin
        case (w.char_code)
          CH_GET: begin
            cmd   = CMD_GET;
            phase = PH_KEY;
          end
          CH_COUNT: begin
            cmd   = CMD_COUNT;
            phase = PH_KEY;
          end
          CH_PUT: begin
            cmd   = CMD_PUT;
            phase = PH_KEY;
          end
          CH_REMOVE: begin
            cmd   = CMD_REMOVE;
            phase = PH_KEY;
          end
          CH_COMMIT: begin
            cmd   = CMD_COMMIT;
            phase = PH_EOL;
          end
          CH_COMMENT: phase = PH_IGNORE;
          default: abort_line(ST_UNKNOWN);
        endcase
      end
      PH_KEY, PH_DATA: return value_step(w.char_code, r);
      PH_EOL: abort_line(ST_TRAILING);
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic string word_text(input out_word_t w);
    return $sformatf("verdict=%0d data=%0d byte=%02h cmd=%0d range=%0d status=%0d",
                     w.is_verdict, w.in_data_part, w.out_byte, w.command_code,
                     w.range_flag, w.status);
  endfunction

  task automatic log_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  initial begin
    clear_line();
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    out_word_t r;
    if (!rst_ni) begin
      clear_line();
      expected_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          log_failure($sformatf("unexpected word: %s", word_text(out_word_i)));
        end else begin
          want = expected_words.pop_front();
          if (want.is_verdict !== out_word_i.is_verdict ||
              want.in_data_part !== out_word_i.in_data_part ||
              want.out_byte !== out_word_i.out_byte ||
              want.command_code !== out_word_i.command_code ||
              want.range_flag !== out_word_i.range_flag ||
              want.status !== out_word_i.status) begin
            log_failure($sformatf("mismatch: expected %s, got %s",
                                  word_text(want), word_text(out_word_i)));
          end
        end
      end
      if (in_valid_i && !in_stall_i && predict_word(in_word_i, r)) begin
        expected_words.insert(expected_words.size(), r);
      end
    end
    pending_o = expected_words.size();
  end

endmodule

@@ bench/tb_command_line_escape_parser_unit.sv @@
`timescale 1ns / 100ps
// Top of the parser testbench: clock, reset, line stimulus and the final verdict.
module tb_command_line_escape_parser_unit;
  import clep_pkg::*;

  localparam int WORD_TARGET  = 1200;
  localparam int QUIET_FROM   = 1000;
  localparam int PAUSE_AT     = 600;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int fail_count;
  int pending;
  int words_sent = 0;
  int idle_odds  = 0;
  int stall_left = 0;
  int cycles     = 0;
  bit paused     = 1'b0;

  logic [7:0] line_chars[$];
  logic [7:0] cmd_chars[6]   = '{CH_GET, CH_COUNT, CH_REMOVE, CH_PUT, CH_COMMIT, CH_COMMENT};
  logic [7:0] esc_letters[6] = '{CH_LOW_T, CH_LOW_R, CH_LOW_N, CH_BSLASH, CH_STAR, CH_COLON};

  always #5 clk = ~clk;

  command_line_escape_parser_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  clep_parse_checker line_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic [7:0] c, input logic le);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{char_code: c, line_end: le};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_line();
    foreach (line_chars[i]) send_word(line_chars[i], 1'b0);
    send_word(8'($urandom), 1'b1);
    line_chars.delete();
  endtask

  task automatic add_char(input logic [7:0] b);
    line_chars.insert(line_chars.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 10) return "0" + v;
    if ($urandom_range(0, 1) == 1) return "a" + v - 8'd10;
    return "A" + v - 8'd10;
  endfunction

  task automatic add_value();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      6: begin
        add_char(CH_BSLASH);
        add_char(esc_letters[$urandom_range(0, 5)]);
      end
      7, 8: begin
        add_char(CH_BSLASH);
        add_char(CH_LOW_X);
        add_char(hex_char());
        add_char(hex_char());
      end
      default: begin
        do b = 8'($urandom); while (b == CH_BSLASH || b == CH_COLON || b == CH_STAR);
        add_char(b);
      end
    endcase
  endtask

  task automatic build_line();
    int kind;
    kind = $urandom_range(0, 5);
    add_char(cmd_chars[kind]);
    if (kind <= 3) begin
      repeat ($urandom_range(0, 6)) add_value();
    end
    if (kind <= 2 && $urandom_range(0, 2) == 0) begin
      add_char(CH_STAR);
    end
    if (kind == 3) begin
      add_char(CH_COLON);
      repeat ($urandom_range(0, 6)) add_value();
    end
    if (kind == 5) begin
      repeat ($urandom_range(0, 6)) add_char(8'($urandom));
    end
  endtask

  task automatic break_line();
    int pos;
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: b = CH_BSLASH;
          1: b = CH_COLON;
          2: b = CH_STAR;
          3: b = CH_LOW_X;
          default: b = 8'($urandom);
        endcase
        pos = $urandom_range(1, line_chars.size());
        line_chars.insert(pos, b);
      end
      1: begin
        repeat ($urandom_range(1, 3)) begin
          if (line_chars.size() > 0) void'(line_chars.pop_back());
        end
      end
      2: line_chars[0] = 8'($urandom);
      default: begin
        line_chars.delete();
        repeat ($urandom_range(0, 8)) add_char(8'($urandom));
      end
    endcase
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_odds = 3;
    send_line();
    line_chars = '{CH_GET, 8'hFF, 8'h00};
    send_line();
    add_text("+\\t:\\xA5");
    send_line();
    add_text("-*");
    send_line();
    add_text("!");
    send_line();
    add_text(">*");
    send_line();
    add_text("Q");
    send_line();
    add_text("#\\q");
    send_line();
    add_text("+a");
    send_line();
    add_text("!x");
    send_line();
    add_text("?\\x");
    send_line();

    while (words_sent < WORD_TARGET) begin
      if (words_sent >= QUIET_FROM) begin
        idle_odds = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0: idle_odds = 0;
          1: idle_odds = 2;
          2: idle_odds = 4;
          default: idle_odds = 8;
        endcase
      end
      build_line();
      if ($urandom_range(0, 9) < 3) break_line();
      send_line();
      if (!paused && words_sent >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/clep_pkg.sv
rtl/core/clep_in_stage.sv
rtl/core/clep_step.sv
rtl/core/clep_out_stage.sv
rtl/core/command_line_escape_parser_unit.sv
rtl/core/clep_checker.sv
bench/clep_parse_checker.sv
bench/tb_command_line_escape_parser_unit.sv
